[rtl/idfl_pkg.sv]
// ----------------------------------------------------------------------------
// idfl_pkg
// Shared widths, codes and defaults for the ID free-list allocator.
// ----------------------------------------------------------------------------
package idfl_pkg;

    localparam int ID_W     = 8;
    localparam int STATUS_W = 2;

    // Largest ID that fits in an ID word.
    localparam int ID_MAX_VAL = (1 << ID_W) - 1;

    // Default for the top level's MAX_ID parameter.
    localparam int MAX_ID_DEF = 255;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam logic ACT_GENERATE = 1'b0;
    localparam logic ACT_RELEASE  = 1'b1;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_EXHAUSTED = 2'd1;
    localparam status_t STAT_IGNORED   = 2'd2;

endpackage

[rtl/idfl_req_if.sv]
// ----------------------------------------------------------------------------
// idfl_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface idfl_req_if;

    logic             valid;
    logic             ready;
    logic             action;
    idfl_pkg::id_t    release_id;

    modport source (output valid, output action, output release_id, input ready);
    modport sink   (input valid, input action, input release_id, output ready);

endinterface

[rtl/idfl_rsp_if.sv]
// ----------------------------------------------------------------------------
// idfl_rsp_if
// Response channel: valid/ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface idfl_rsp_if;

    logic                valid;
    logic                ready;
    idfl_pkg::id_t       id_out;
    idfl_pkg::status_t   status;

    modport source (output valid, output id_out, output status, input ready);
    modport sink   (input valid, input id_out, input status, output ready);

endinterface

[rtl/id_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// id_free_list_allocator
// Hands out unique nonzero IDs from a LIFO free stack and takes them back.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over bitmap entries 0 to
// min(MAX_ID, 255), during which no request word is taken. Each request is
// then handled in order: on acceptance the stack top and the bitmap bit are
// read from their RAMs, whose reads are registered; in the execute state the
// block decides, writes back and loads the result into the output register. A
// request is taken while the previous response still waits in the output
// register; the write-back stalls only if that register is still full.
// Generate pops the most recently freed ID, or raises the high-water mark when
// the stack is empty, and reports exhausted once that mark reaches the limit.
// Releasing zero, an ID above the limit or an ID not currently assigned is
// ignored and flagged; the ID is echoed in every case.
module id_free_list_allocator #(
    parameter int MAX_ID = idfl_pkg::MAX_ID_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    idfl_req_if.sink   req,
    idfl_rsp_if.source rsp
);

    localparam int IW        = idfl_pkg::ID_W;
    localparam int ID_LIMIT  = (MAX_ID > idfl_pkg::ID_MAX_VAL) ? idfl_pkg::ID_MAX_VAL : MAX_ID;
    localparam int STACK_DEP = ID_LIMIT;
    localparam int MAP_DEP   = ID_LIMIT + 1;
    localparam int SA        = $clog2(STACK_DEP);
    localparam int MA        = $clog2(MAP_DEP);

    localparam logic [IW-1:0] LIMIT_V = IW'(ID_LIMIT);
    localparam logic [MA-1:0] CLR_END = MA'(ID_LIMIT);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [MA-1:0]      clr_reg, clr_next;
    logic [IW-1:0]      free_count_reg, free_count_next;
    logic [IW-1:0]      high_water_reg, high_water_next;
    logic               action_reg;
    logic [IW-1:0]      rid_reg;
    logic               out_valid_reg, out_valid_next;
    idfl_pkg::id_t      out_id_reg;
    idfl_pkg::status_t  out_status_reg;

    logic               accept;
    logic               commit;
    logic [IW-1:0]      count_dec;

    logic               stack_we;
    logic [SA-1:0]      stack_waddr;
    logic [IW-1:0]      stack_wdata;
    logic [SA-1:0]      stack_raddr;
    logic [IW-1:0]      stack_rdata;

    logic               map_we;
    logic [MA-1:0]      map_waddr;
    logic               map_wdata;
    logic [MA-1:0]      map_raddr;
    logic               map_rdata;

    logic               stack_empty;
    logic               hw_full;
    logic               rel_bad;
    logic               push_ok;
    idfl_pkg::id_t      res_id;
    idfl_pkg::status_t  res_status;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    // Read addresses are presented with the request word, so the data is
    // there in the execute cycle.
    assign count_dec   = free_count_reg - IW'(1);
    assign stack_raddr = count_dec[SA-1:0];
    assign map_raddr   = req.release_id[MA-1:0];

    idfl_ram #(
        .WIDTH (IW),
        .DEPTH (STACK_DEP)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (accept),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    idfl_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEP)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (accept),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Decision for the request in the execute state.
    always_comb
    begin
        stack_empty = (free_count_reg == '0);
        hw_full     = (high_water_reg >= LIMIT_V);
        rel_bad     = (rid_reg == '0) || (rid_reg > LIMIT_V) || !map_rdata;
        push_ok     = !rel_bad && (free_count_reg < LIMIT_V);
        res_id      = rid_reg;
        res_status  = idfl_pkg::STAT_OK;
        if (action_reg == idfl_pkg::ACT_GENERATE)
        begin
            if (!stack_empty)
            begin
                res_id = stack_rdata;
            end
            else if (hw_full)
            begin
                res_id     = '0;
                res_status = idfl_pkg::STAT_EXHAUSTED;
            end
            else
            begin
                res_id = high_water_reg + IW'(1);
            end
        end
        else if (rel_bad)
        begin
            res_status = idfl_pkg::STAT_IGNORED;
        end
    end

    // Write-back to both RAMs and the counters, the clearing pass and the state sequencing.
    always_comb
    begin
        stack_we        = 1'b0;
        stack_waddr     = free_count_reg[SA-1:0];
        stack_wdata     = rid_reg;
        map_we          = 1'b0;
        map_waddr       = clr_reg;
        map_wdata       = 1'b0;
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        clr_next        = clr_reg;
        state_next      = state_reg;

        case (state_reg)
            S_CLEAR:
            begin
                map_we   = 1'b1;
                clr_next = clr_reg + MA'(1);
                // The stack starts out holding ID one in its bottom entry.
                if (clr_reg == '0)
                begin
                    stack_we    = 1'b1;
                    stack_waddr = '0;
                    stack_wdata = IW'(1);
                end
                if (clr_reg == CLR_END)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                    if (action_reg == idfl_pkg::ACT_GENERATE)
                    begin
                        if (res_status == idfl_pkg::STAT_OK)
                        begin
                            map_we    = 1'b1;
                            map_waddr = res_id[MA-1:0];
                            map_wdata = 1'b1;
                            if (!stack_empty)
                            begin
                                free_count_next = count_dec;
                            end
                            else
                            begin
                                high_water_next = res_id;
                            end
                        end
                    end
                    else if (!rel_bad)
                    begin
                        map_we    = 1'b1;
                        map_waddr = rid_reg[MA-1:0];
                        map_wdata = 1'b0;
                        if (push_ok)
                        begin
                            stack_we        = 1'b1;
                            free_count_next = free_count_reg + IW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            free_count_reg <= IW'(1);
            high_water_reg <= IW'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= req.action;
            rid_reg    <= req.release_id;
        end
        if (commit)
        begin
            out_id_reg     <= res_id;
            out_status_reg <= res_status;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.id_out = out_id_reg;
    assign rsp.status = out_status_reg;

endmodule

[rtl/idfl_ram.sv]
// ----------------------------------------------------------------------------
// idfl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module idfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
